FILE: rtl/core/radix_digit_converter_defines.svh
// assertion macros for the radix digit converter checker
// no dependencies; included by files that hold concurrent assertions
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// property sampled on the block clock, off while reset is low
`define RDC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define RDC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RDC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rdc_pkg.sv
// shared types, constants and helper functions of the radix digit converter
// no dependencies; imported by the controller, datapath and top level
package rdc_pkg;

  localparam int unsigned VALUE_W         = 31;
  localparam int unsigned RADIX_W         = 5;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned CHAR_W          = 7;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned APB_ADDR_W      = 3;
  localparam int unsigned RESULT_LIMIT    = 31;

  // divider works on a padded word, a few bits per cycle
  localparam int unsigned WORK_W          = 32;
  localparam int unsigned BITS_PER_STEP   = 4;
  localparam int unsigned STEPS_PER_DIGIT = WORK_W / BITS_PER_STEP;
  localparam int unsigned STEP_CNT_W      = $clog2(STEPS_PER_DIGIT);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  // word index of the radix register (byte address bit 2)
  localparam logic RADIX_WORD = 1'b0;

  localparam logic [DIGIT_W-1:0] DEC_LIMIT   = 4'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_ALPHA = 7'd55;

  typedef struct packed {
    logic load;    // capture value and base, clear digit count
    logic step;    // one divider step
    logic commit;  // last step of a digit: store remainder
    logic rd;      // read one stored digit to the output
  } rdc_cmd_t;

  typedef struct packed {
    logic quot_zero;  // quotient after this step is zero
    logic ptr_zero;   // read pointer at the least significant digit
  } rdc_stat_t;

  function automatic logic [RADIX_W-1:0] eff_base(logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    if (r < RADIX_MIN) begin
      b = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      b = RADIX_MAX;
    end else begin
      b = r;
    end
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_ascii(logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_LIMIT) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_ALPHA + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/rdc_ctrl.sv
// sequencing state machine of the radix digit converter
// depends on rdc_pkg for the command and status structs
module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output rdc_cmd_t  cmd_o,
  input  rdc_stat_t stat_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [STEP_CNT_W-1:0] step_q, step_d;
  logic                  last_step;

  assign last_step = (step_q == STEP_CNT_W'(STEPS_PER_DIGIT - 1));
  assign busy_o    = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (last_step) begin
          cmd_o.commit = 1'b1;
          step_d       = '0;
          if (stat_i.quot_zero) begin
            state_d = ST_EMIT;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_EMIT: begin
        cmd_o.rd = 1'b1;
        if (stat_i.ptr_zero) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

FILE: rtl/core/rdc_dpath.sv
// divider, digit store and output registers of the radix digit converter
// depends on rdc_pkg for widths, command/status structs and digit encoding
module rdc_dpath
  import rdc_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rdc_cmd_t            cmd_i,
  output rdc_stat_t           stat_o,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [RADIX_W-1:0]  radix_i,
  output logic [CHAR_W-1:0]   digit_char_o,
  output logic [DIGIT_W-1:0]  digit_value_o,
  output logic                last_digit_o,
  output logic                digit_strobe_o
);

  localparam int unsigned CAP   = (MAX_DIGITS < RESULT_LIMIT) ? MAX_DIGITS : RESULT_LIMIT;
  localparam int unsigned IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int unsigned CNT_W = $clog2(CAP + 1);

  logic [DIGIT_W-1:0] store_mem [CAP];

  logic [WORK_W-1:0]  work_q, work_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] base_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [IDX_W-1:0]   ptr_q;
  logic [DIGIT_W-1:0] rd_data_q;
  logic               last_q;
  logic               strobe_q;
  logic               room;

  // four restoring steps per cycle, remainder stays below the base
  always_comb begin
    logic [RADIX_W-1:0]       r;
    logic [RADIX_W-1:0]       t;
    logic [BITS_PER_STEP-1:0] qb;
    r  = rem_q;
    qb = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      t = {r[RADIX_W-2:0], work_q[WORK_W-1-i]};
      if (t >= base_q) begin
        t = t - base_q;
        qb[BITS_PER_STEP-1-i] = 1'b1;
      end
      r = t;
    end
    rem_d  = r;
    work_d = {work_q[WORK_W-BITS_PER_STEP-1:0], qb};
  end

  assign room             = (cnt_q < CNT_W'(CAP));
  assign stat_o.quot_zero = (work_d == '0);
  assign stat_o.ptr_zero  = (ptr_q == '0);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q <= {{(WORK_W - VALUE_W){1'b0}}, value_i};
      rem_q  <= '0;
      base_q <= eff_base(radix_i);
    end else if (cmd_i.step) begin
      work_q <= work_d;
      rem_q  <= cmd_i.commit ? '0 : rem_d;
    end
  end

  // digit store, least significant first
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && room) begin
      store_mem[cnt_q[IDX_W-1:0]] <= rem_d[DIGIT_W-1:0];
    end
    if (cmd_i.rd) begin
      rd_data_q <= store_mem[ptr_q];
      last_q    <= (ptr_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ptr_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.rd;
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.commit && room) begin
        cnt_q <= cnt_q + 1'b1;
        ptr_q <= cnt_q[IDX_W-1:0];
      end else if (cmd_i.rd) begin
        ptr_q <= ptr_q - 1'b1;
      end
    end
  end

  assign digit_value_o  = rd_data_q;
  assign digit_char_o   = digit_ascii(rd_data_q);
  assign last_digit_o   = last_q;
  assign digit_strobe_o = strobe_q;

endmodule

FILE: rtl/core/radix_digit_converter.sv
// top level of the radix digit converter: apb register file, controller, datapath
// depends on rdc_pkg, rdc_ctrl and rdc_dpath
// usage
//   request channel: drive value_i and raise start; the request is taken at the
//   clock edge where start is high and busy is low. busy stays high until the
//   last digit has been read from the digit store.
//   result channel: one digit per cycle, most significant first, marked by
//   digit_strobe_o for exactly one cycle; last_digit_o flags the least
//   significant digit. the receiver cannot stall; digits are never held back.
//   config: apb register radix at byte address 0 (base 2..16, values below 2
//   act as 2, above 16 as 16, reset 10). write it only while busy is low.
// sequence
//   each digit is divided out four quotient bits per cycle. busy stays high
//   from the accept edge while every digit is divided out and then emitted.
//   the first digit is driven once all digits have been divided out, the
//   last one as busy drops, so the next request can go in at the edge that
//   takes the last digit.
// reset
//   rst_ni clears the controller, counters and strobe and loads radix 10;
//   the digit store is not cleared, every entry is written before it is read.
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_W-1:0]    value_i,
  // digit results
  output logic [CHAR_W-1:0]     digit_char_o,
  output logic [DIGIT_W-1:0]    digit_value_o,
  output logic                  last_digit_o,
  output logic                  digit_strobe_o,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [RADIX_W-1:0] radix_q;
  logic               cfg_wr;
  logic               sel_radix;
  rdc_cmd_t           cmd;
  rdc_stat_t          stat;

  // apb: pready tied high, only word 0 is implemented
  assign pready    = 1'b1;
  assign sel_radix = (paddr[2] == RADIX_WORD);
  assign cfg_wr    = psel && penable && pwrite && sel_radix;
  assign prdata    = sel_radix ? {{(APB_DATA_W - RADIX_W){1'b0}}, radix_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_wr) begin
      radix_q <= pwdata[RADIX_W-1:0];
    end
  end

  // sequencing: idle -> divide each digit -> emit the digits
  rdc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  // divider, digit store and registered digit output
  rdc_dpath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .value_i        (value_i),
    .radix_i        (radix_q),
    .digit_char_o   (digit_char_o),
    .digit_value_o  (digit_value_o),
    .last_digit_o   (last_digit_o),
    .digit_strobe_o (digit_strobe_o)
  );

endmodule

FILE: rtl/core/rdc_checker.sv
// port-level checker for the radix digit converter, bound to the top level
// depends on radix_digit_converter_defines.svh for the assertion macros
`include "radix_digit_converter_defines.svh"

module rdc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [6:0] digit_char_o,
  input logic [3:0] digit_value_o,
  input logic       last_digit_o,
  input logic       digit_strobe_o
);

  // a digit only follows a cycle in which a request was in progress
  `RDC_ASSERT_IMP(a_strobe_after_busy, digit_strobe_o, $past(busy), "digit without request")

  // accepted request starts dividing, nothing comes out the next cycle
  `RDC_ASSERT_NXT(a_accept_divides, start && !busy, busy && !digit_strobe_o, "bad accept")

  // digits of one request come back to back until the last one
  `RDC_ASSERT_NXT(a_digits_contiguous, digit_strobe_o && !last_digit_o, digit_strobe_o, "gap in digits")

  // the block is free again once the last digit is out
  `RDC_ASSERT_IMP(a_last_frees, digit_strobe_o && last_digit_o, !busy, "busy after last digit")

  // character code matches the digit value
  `RDC_ASSERT(a_char_code, !digit_strobe_o || (digit_char_o == ((digit_value_o < 4'd10) ? (7'd48 + 7'(digit_value_o)) : (7'd55 + 7'(digit_value_o)))), "bad digit character")

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .digit_char_o   (digit_char_o),
  .digit_value_o  (digit_value_o),
  .last_digit_o   (last_digit_o),
  .digit_strobe_o (digit_strobe_o)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for radix_digit_converter: directed table, then random values
// depends on rdc_pkg and the radix_digit_converter rtl
module tb;
  import rdc_pkg::*;

  // ascii offsets for digits 0-9 and for digits 10-15 (value + 55 gives 'A'..'F')
  localparam logic [CHAR_W-1:0]     CH_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0]     CH_ALPHA    = 7'h37;
  localparam int unsigned           DEC_DIGITS  = 10;
  localparam int unsigned           BASE_LO     = 2;
  localparam int unsigned           BASE_HI     = 16;
  localparam logic [APB_ADDR_W-1:0] RADIX_ADDR  = '0;
  localparam int                    N_DIR       = 25;
  localparam int                    N_PHASES    = 10;
  localparam int                    PHASE_ITEMS = 11;
  localparam int                    TAIL_CYCLES = 300;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [DIGIT_W-1:0] val;
    logic               last;
  } digit_t;

  // one directed request; an empty text means the digits come from the predictor
  typedef struct {
    logic [RADIX_W-1:0] radix;
    logic [VALUE_W-1:0] value;
    string              text;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [VALUE_W-1:0]    value_i;
  logic [CHAR_W-1:0]     digit_char_o;
  logic [DIGIT_W-1:0]    digit_value_o;
  logic                  last_digit_o;
  logic                  digit_strobe_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // digits still owed by the block, oldest first
  digit_t             pending_digits[$];
  int                 err_count = 0;
  logic [RADIX_W-1:0] cur_radix;
  int                 burst_left = 0;

  // extremes, every radix edge case, out-of-range radix values, zero
  dir_row_t dir_rows [N_DIR] = '{
    '{5'd10, 31'd0,          "0"},
    '{5'd10, 31'h7FFFFFFF,   "2147483647"},
    '{5'd10, 31'd9,          "9"},
    '{5'd10, 31'd10,         "10"},
    '{5'd10, 31'h2AAAAAAA,   ""},
    '{5'd16, 31'h7FFFFFFF,   "7FFFFFFF"},
    '{5'd16, 31'h00ABCDEF,   "ABCDEF"},
    '{5'd16, 31'd15,         "F"},
    '{5'd16, 31'h55555555,   "55555555"},
    '{5'd2,  31'h7FFFFFFF,   "1111111111111111111111111111111"},
    '{5'd2,  31'd0,          "0"},
    '{5'd2,  31'h40000000,   "1000000000000000000000000000000"},
    '{5'd0,  31'd5,          "101"},
    '{5'd1,  31'd6,          "110"},
    '{5'd17, 31'd255,        "FF"},
    '{5'd31, 31'h7FFFFFFF,   "7FFFFFFF"},
    '{5'd20, 31'd16,         "10"},
    '{5'd8,  31'h7FFFFFFF,   "17777777777"},
    '{5'd9,  31'd81,         "100"},
    '{5'd12, 31'd11,         "B"},
    '{5'd3,  31'h7FFFFFFF,   ""},
    '{5'd5,  31'h55555555,   ""},
    '{5'd7,  31'd12345,      ""},
    '{5'd13, 31'h2AAAAAAA,   ""},
    '{5'd14, 31'h12345678,   ""}
  };

  radix_digit_converter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_i        (value_i),
    .digit_char_o   (digit_char_o),
    .digit_value_o  (digit_value_o),
    .last_digit_o   (last_digit_o),
    .digit_strobe_o (digit_strobe_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4_000_000;
    $display("tb failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_count++;
  endtask

  // digits of value in the given radix register setting, most significant first
  function automatic void predict_digits(input logic [VALUE_W-1:0] value,
                                         input logic [RADIX_W-1:0] radix);
    int unsigned        base;
    logic [VALUE_W-1:0] quot;
    logic [DIGIT_W-1:0] rems [RESULT_LIMIT];
    int                 n;
    digit_t             d;
    // radix 0/1 act as binary, 17..31 as hex
    if (radix < BASE_LO) begin
      base = BASE_LO;
    end else if (radix > BASE_HI) begin
      base = BASE_HI;
    end else begin
      base = 32'(radix);
    end
    quot = value;
    n = 0;
    // repeated division, remainders least significant first
    do begin
      if (n < RESULT_LIMIT) begin
        rems[n] = DIGIT_W'(quot % base);
        n++;
      end
      quot = VALUE_W'(quot / base);
    end while (quot != 0);
    for (int k = n - 1; k >= 0; k--) begin
      d.val  = rems[k];
      d.ch   = (rems[k] < DEC_DIGITS) ? CH_ZERO + CHAR_W'(rems[k])
                                      : CH_ALPHA + CHAR_W'(rems[k]);
      d.last = (k == 0);
      pending_digits.push_back(d);
    end
  endfunction

  // digits typed in as text, e.g. "7FFFFFFF"
  function automatic void queue_text(input string s);
    byte    c;
    digit_t d;
    for (int k = 0; k < s.len(); k++) begin
      c      = s[k];
      d.ch   = c[CHAR_W-1:0];
      d.val  = (c[CHAR_W-1:0] >= CH_ALPHA + CHAR_W'(DEC_DIGITS))
               ? DIGIT_W'(c[CHAR_W-1:0] - CH_ALPHA) : DIGIT_W'(c[CHAR_W-1:0] - CH_ZERO);
      d.last = (k == s.len() - 1);
      pending_digits.push_back(d);
    end
  endfunction

  // mix of wide, narrow, power-of-two and shifted values
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = VALUE_W'($urandom);
      1: v = VALUE_W'($urandom_range(0, 255));
      2: v = (VALUE_W'(1) << $urandom_range(0, VALUE_W - 1)) - VALUE_W'($urandom_range(0, 1));
      default: v = VALUE_W'($urandom >> $urandom_range(0, 30));
    endcase
    return v;
  endfunction

  // raise start with the value and hold it until the block takes the request
  task automatic issue(input logic [VALUE_W-1:0] v);
    value_i <= v;
    start   <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // bursts of back-to-back requests separated by gaps, some short, some long
  // enough to land anywhere inside a conversion
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 12);
      start   <= 1'b0;
      value_i <= VALUE_W'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
  endtask

  // wait until every owed digit has come out and the block is idle
  task automatic drain_digits();
    start <= 1'b0;
    while (pending_digits.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] a, input logic [APB_DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] a, output logic [APB_DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_radix_reg(input logic [RADIX_W-1:0] want);
    logic [APB_DATA_W-1:0] rd;
    apb_read(RADIX_ADDR, rd);
    if (rd !== APB_DATA_W'(want))
      report_mismatch($sformatf("radix readback %0d, want %0d", rd, want));
  endtask

  // reprogram the radix only with the block idle; junk_hi puts junk in the unused upper bits
  task automatic set_radix(input logic [RADIX_W-1:0] r, input bit junk_hi);
    logic [APB_DATA_W-1:0] wd;
    drain_digits();
    wd = APB_DATA_W'(r);
    if (junk_hi) wd[APB_DATA_W-1:RADIX_W] = (APB_DATA_W - RADIX_W)'($urandom);
    apb_write(RADIX_ADDR, wd);
    @(posedge clk_i);
    check_radix_reg(r);
    cur_radix = r;
  endtask

  // result checker: the block cannot be stalled, so every strobe is a digit to check
  always @(posedge clk_i) begin : digit_check
    digit_t want;
    if (rst_ni && digit_strobe_o) begin
      if (pending_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected digit char %0d value %0d last %0b",
                                  digit_char_o, digit_value_o, last_digit_o));
      end else begin
        want = pending_digits.pop_front();
        if (digit_char_o !== want.ch || digit_value_o !== want.val ||
            last_digit_o !== want.last)
          report_mismatch($sformatf("digit char %0d/%0d value %0d/%0d last %0b/%0b (got/want)",
                                    digit_char_o, want.ch, digit_value_o, want.val,
                                    last_digit_o, want.last));
      end
    end
  end

  initial begin : stimulus
    logic [VALUE_W-1:0] v;
    logic [RADIX_W-1:0] r;
    // every input known from time zero
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    value_i <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cur_radix = RADIX_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // radix comes out of reset as decimal
    check_radix_reg(RADIX_RESET);
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].radix != cur_radix) set_radix(dir_rows[i].radix, 1'b0);
      pace();
      issue(dir_rows[i].value);
      if (dir_rows[i].text.len() == 0) begin
        predict_digits(dir_rows[i].value, cur_radix);
      end else begin
        queue_text(dir_rows[i].text);
      end
    end

    // random phases: binary and hex first, then mostly legal radix values
    // with the occasional out-of-range one
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 0) begin
        r = RADIX_W'(BASE_LO);
      end else if (p == 1) begin
        r = RADIX_W'(BASE_HI);
      end else if ($urandom_range(0, 3) == 0) begin
        r = RADIX_W'($urandom_range(0, 31));
      end else begin
        r = RADIX_W'($urandom_range(BASE_LO, BASE_HI));
      end
      set_radix(r, 1'b1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        v = rand_value();
        pace();
        issue(v);
        predict_digits(v, cur_radix);
      end
    end

    drain_digits();
    // catch any stray digit after the last one owed
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
